[sv/tmtw_pkg.sv]
// Shared constants, types and helpers for the text-mode terminal writer.
package tmtw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int DEPTH   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CELL_W  = 16;

  // Field widths fixed by the stream format
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ACT_W   = 2;
  localparam int BYTE_W  = 8;

  // First address past the rows that a scroll copies
  localparam int COPY_N  = (ROWS - 1) * COLUMNS;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [BYTE_W-1:0] RESET_COLOR  = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0F20;

  // Clear cycles the row attribute through 1..CLEAR_MOD
  localparam int CLEAR_MOD = 15;

  // What a fill sweep writes
  typedef enum logic [1:0] {
    FILL_RESET = 2'd0,
    FILL_CLEAR = 2'd1,
    FILL_BLANK = 2'd2
  } fill_mode_t;

  // Linear cell address of (row, col)
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[sv/tmtw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/text_mode_terminal_writer_unit.sv]
// Top level of the text-mode terminal writer: screen memory, cursor and sequencer.
//
// Usage: each request on the in_ channel is one action (put character, read
// cell, clear screen); each request yields exactly one result on the out_
// channel with the cursor after the action and, for a read, the cell bytes.
// cfg_wr_en/cfg_wr_data set the text color; write it only while idle.
//
// Steps per request, set by the single write port of the screen memory:
//   put without scroll, unused action: accept, then result registered
//   read: accept, registered memory read, then result registered
//   put that scrolls: accept, copy of (ROWS-1)*COLUMNS cells, COLUMNS blank, result
//   clear: accept, sweep over ROWS*COLUMNS cells, result
// One request is worked on at a time; the next one is taken while the
// previous result still waits in the output register.
//
// Reset: a sweep writes the blank cell to every one of the ROWS*COLUMNS = 2000
// screen entries; in_tready stays low during it. The cursor homes and the color
// returns to 15.
// Stall: a result held by out_tready low keeps the next finished result
// waiting inside; no result is lost or repeated.
module text_mode_terminal_writer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: action[1:0], char_code[9:2], read_row[14:10], read_col[21:15]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: cursor_row[4:0], cursor_col[11:5], cell_char[19:12],
  // cell_attr[27:20]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_COPY = 5'b00100,
    S_FILL = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // Input fields
  logic [tmtw_pkg::ACT_W-1:0]  in_action;
  logic [tmtw_pkg::BYTE_W-1:0] in_char;
  logic [tmtw_pkg::ROW_W-1:0]  in_row;
  logic [tmtw_pkg::COL_W-1:0]  in_col;

  assign in_action = in_tdata[1:0];
  assign in_char   = in_tdata[9:2];
  assign in_row    = in_tdata[14:10];
  assign in_col    = in_tdata[21:15];

  // Registers
  state_t                        state_r, state_nxt;
  tmtw_pkg::fill_mode_t          fill_mode_r, fill_mode_nxt;
  logic [tmtw_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [tmtw_pkg::COL_W-1:0]    fill_col_r, fill_col_nxt;
  logic [3:0]                    fill_mod_r, fill_mod_nxt;
  logic [tmtw_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [tmtw_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [tmtw_pkg::BYTE_W-1:0]   color_r;
  logic                          rd_ok_r, rd_ok_nxt;
  logic [tmtw_pkg::BYTE_W-1:0]   res_char_r, res_char_nxt;
  logic [tmtw_pkg::BYTE_W-1:0]   res_attr_r, res_attr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [31:0]                   out_data_r, out_data_nxt;

  // Memory port
  logic                          mem_we;
  logic [tmtw_pkg::ADDR_W-1:0]   mem_waddr;
  logic [tmtw_pkg::CELL_W-1:0]   mem_wdata;
  logic [tmtw_pkg::ADDR_W-1:0]   mem_raddr;
  logic [tmtw_pkg::CELL_W-1:0]   mem_rdata;

  // Put-character cursor math
  logic                          accept;
  logic                          row_step;
  logic                          scroll;
  logic [tmtw_pkg::COL_W-1:0]    put_col;
  logic [tmtw_pkg::COL_W-1:0]    wr_col;
  logic                          rd_in_range;
  logic                          out_free;
  logic [tmtw_pkg::CELL_W-1:0]   fill_value;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign rd_in_range = (in_row < tmtw_pkg::ROW_W'(tmtw_pkg::ROWS)) &&
                       (in_col < tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS));

  // Cursor after a put
  always_comb begin
    row_step = 1'b0;
    put_col  = col_r;
    wr_col   = col_r;
    case (in_char)
      tmtw_pkg::CH_NEWLINE: begin
        put_col  = '0;
        row_step = 1'b1;
      end
      tmtw_pkg::CH_BACKSPACE: begin
        put_col = (col_r == '0) ? '0 : col_r - 1'b1;
        wr_col  = put_col;
      end
      default: begin
        if (col_r == tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS - 1)) begin
          put_col  = '0;
          row_step = 1'b1;
        end else begin
          put_col = col_r + 1'b1;
        end
      end
    endcase
    scroll = row_step && (row_r == tmtw_pkg::ROW_W'(tmtw_pkg::ROWS - 1));
  end

  // Value written by a fill sweep
  always_comb begin
    case (fill_mode_r)
      tmtw_pkg::FILL_RESET: fill_value = tmtw_pkg::RESET_CELL;
      tmtw_pkg::FILL_CLEAR: fill_value = {4'd0, fill_mod_r + 4'd1, tmtw_pkg::CH_SPACE};
      tmtw_pkg::FILL_BLANK: fill_value = {color_r, tmtw_pkg::CH_SPACE};
      default:              fill_value = tmtw_pkg::RESET_CELL;
    endcase
  end

  // Sequencer and memory port control
  always_comb begin
    state_nxt     = state_r;
    fill_mode_nxt = fill_mode_r;
    addr_nxt      = addr_r;
    fill_col_nxt  = fill_col_r;
    fill_mod_nxt  = fill_mod_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    rd_ok_nxt     = rd_ok_r;
    res_char_nxt  = res_char_r;
    res_attr_nxt  = res_attr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = fill_value;
    mem_raddr     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_char_nxt = '0;
          res_attr_nxt = '0;
          state_nxt    = S_DONE;
          case (in_action)
            tmtw_pkg::ACT_PUT: begin
              // write the cell now, cursor moves at once
              mem_we    = (in_char != tmtw_pkg::CH_NEWLINE);
              mem_waddr = tmtw_pkg::cell_addr(row_r, wr_col);
              mem_wdata = (in_char == tmtw_pkg::CH_BACKSPACE) ?
                          {color_r, tmtw_pkg::CH_SPACE} : {color_r, in_char};
              col_nxt   = put_col;
              if (scroll) begin
                addr_nxt  = '0;
                state_nxt = S_COPY;
              end else if (row_step) begin
                row_nxt = row_r + 1'b1;
              end
            end
            tmtw_pkg::ACT_READ: begin
              mem_raddr = rd_in_range ? tmtw_pkg::cell_addr(in_row, in_col) : '0;
              rd_ok_nxt = rd_in_range;
              state_nxt = S_READ;
            end
            tmtw_pkg::ACT_CLEAR: begin
              row_nxt       = '0;
              col_nxt       = '0;
              addr_nxt      = '0;
              fill_col_nxt  = '0;
              fill_mod_nxt  = '0;
              fill_mode_nxt = tmtw_pkg::FILL_CLEAR;
              state_nxt     = S_FILL;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        if (rd_ok_r) begin
          res_char_nxt = mem_rdata[7:0];
          res_attr_nxt = mem_rdata[15:8];
        end
        state_nxt = S_DONE;
      end

      // Scroll: read the cell one row below, write it back in the next cycle
      S_COPY: begin
        mem_we    = (addr_r != '0);
        mem_waddr = addr_r - 1'b1;
        mem_wdata = mem_rdata;
        if (addr_r == tmtw_pkg::ADDR_W'(tmtw_pkg::COPY_N)) begin
          fill_mode_nxt = tmtw_pkg::FILL_BLANK;
          state_nxt     = S_FILL;
        end else begin
          mem_raddr = addr_r + tmtw_pkg::ADDR_W'(tmtw_pkg::COLUMNS);
          addr_nxt  = addr_r + 1'b1;
        end
      end

      // Sweep writes one cell a cycle up to the last entry
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = fill_value;
        if (addr_r == tmtw_pkg::ADDR_W'(tmtw_pkg::DEPTH - 1)) begin
          state_nxt = (fill_mode_r == tmtw_pkg::FILL_RESET) ? S_IDLE : S_DONE;
        end else begin
          addr_nxt = addr_r + 1'b1;
          if (fill_col_r == tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS - 1)) begin
            fill_col_nxt = '0;
            fill_mod_nxt = (fill_mod_r == 4'(tmtw_pkg::CLEAR_MOD - 1)) ?
                           4'd0 : fill_mod_r + 4'd1;
          end else begin
            fill_col_nxt = fill_col_r + 1'b1;
          end
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, res_attr_r, res_char_r, col_r, row_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_mode_r <= tmtw_pkg::FILL_RESET;
      addr_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      color_r     <= tmtw_pkg::RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_mode_r <= fill_mode_nxt;
      addr_r      <= addr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fill_col_r <= fill_col_nxt;
    fill_mod_r <= fill_mod_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    out_data_r <= out_data_nxt;
  end

  // Screen store
  tmtw_ram #(
    .WIDTH (tmtw_pkg::CELL_W),
    .DEPTH (tmtw_pkg::DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[sim/tb.sv]
// Testbench for the text-mode terminal writer: screen tracker, stream drivers and checks.
`timescale 1ns / 1ps

import tmtw_pkg::*;

// One request on the input stream
typedef struct packed {
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] ch;
  logic [ROW_W-1:0]  rrow;
  logic [COL_W-1:0]  rcol;
} term_req_t;

// Cursor and cell bytes that one request should return
typedef struct packed {
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [BYTE_W-1:0] ch;
  logic [BYTE_W-1:0] attr;
} term_status_t;

// Tracks the screen contents and cursor, and holds the status words still due
class screen_tracker;
  logic [CELL_W-1:0] cells [DEPTH];
  int                crow;
  int                ccol;
  logic [BYTE_W-1:0] color;
  term_status_t      awaited[$];
  int                errors;
  int                checked;
  int                noted;
  int                reads;
  int                scrolls;
  int                clears;

  function new();
    foreach (cells[i]) cells[i] = RESET_CELL;
    crow = 0;
    ccol = 0;
    color = RESET_COLOR;
    errors = 0;
    checked = 0;
    noted = 0;
    reads = 0;
    scrolls = 0;
    clears = 0;
  endfunction

  function logic [CELL_W-1:0] blank();
    return {color, CH_SPACE};
  endfunction

  // Shift every row up one and blank the bottom row
  function void scroll_up();
    for (int i = 0; i < COPY_N; i++) cells[i] = cells[i + COLUMNS];
    for (int c = 0; c < COLUMNS; c++) cells[COPY_N + c] = blank();
    if (crow > 0) crow--;
    scrolls++;
  endfunction

  function void put_char(logic [BYTE_W-1:0] ch);
    if (ch == CH_NEWLINE) begin
      ccol = 0;
      crow++;
    end else if (ch == CH_BACKSPACE) begin
      if (ccol > 0) ccol--;
      cells[crow * COLUMNS + ccol] = blank();
    end else begin
      cells[crow * COLUMNS + ccol] = {color, ch};
      ccol++;
      if (ccol >= COLUMNS) begin
        ccol = 0;
        crow++;
      end
    end
    if (crow >= ROWS) scroll_up();
  endfunction

  // Row y gets a space with attribute (y mod 15) + 1
  function void clear_screen();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLUMNS; c++)
        cells[r * COLUMNS + c] = {BYTE_W'(r % CLEAR_MOD + 1), CH_SPACE};
    crow = 0;
    ccol = 0;
    clears++;
  endfunction

  // Apply one accepted request and queue the status it must produce
  function void note_request(term_req_t r);
    term_status_t s;
    logic [CELL_W-1:0] v;
    s.ch = '0;
    s.attr = '0;
    case (r.action)
      ACT_PUT: put_char(r.ch);
      ACT_READ: begin
        reads++;
        if (r.rrow < ROWS && r.rcol < COLUMNS) begin
          v = cells[r.rrow * COLUMNS + r.rcol];
          s.ch = v[7:0];
          s.attr = v[15:8];
        end
      end
      ACT_CLEAR: clear_screen();
      default: ;
    endcase
    s.row = ROW_W'(crow);
    s.col = COL_W'(ccol);
    awaited.push_back(s);
    noted++;
  endfunction

  task report_mismatch(string what, int got, int want);
    errors++;
    $display("tb: mismatch on %s after %0d results: got %0d, want %0d",
             what, checked, got, want);
  endtask

  // Compare one result word against the oldest status still due
  task check_result(logic [31:0] d);
    term_status_t s;
    if (awaited.size() == 0) begin
      report_mismatch("unexpected result", int'(d), 0);
    end else begin
      s = awaited.pop_front();
      if (d[4:0] !== s.row) report_mismatch("cursor_row", int'(d[4:0]), int'(s.row));
      if (d[11:5] !== s.col) report_mismatch("cursor_col", int'(d[11:5]), int'(s.col));
      if (d[19:12] !== s.ch) report_mismatch("cell_char", int'(d[19:12]), int'(s.ch));
      if (d[27:20] !== s.attr) report_mismatch("cell_attr", int'(d[27:20]), int'(s.attr));
      checked++;
    end
  endtask
endclass

module tb;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Longest correct stretch without a handshake is a scroll
  localparam int STALL_LIMIT = 12000;
  // Scrolls and clears each cost a screen walk; keep their total bounded
  localparam int WALK_BUDGET = 220;
  localparam int SEG_ITEMS   = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  int send_idle = 15;
  int recv_idle = 48;
  int stall_cycles = 0;

  screen_tracker sb;

  text_mode_terminal_writer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver pacing
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Result check and handshake watchdog
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic term_req_t mk_req(logic [ACT_W-1:0] a, logic [BYTE_W-1:0] ch,
                                       int row, int col);
    term_req_t r;
    r.action = a;
    r.ch = ch;
    r.rrow = ROW_W'(row);
    r.rcol = COL_W'(col);
    return r;
  endfunction

  // Put or clear with random don't-care fields
  function automatic term_req_t mk_cmd(logic [ACT_W-1:0] a, logic [BYTE_W-1:0] ch);
    return mk_req(a, ch, $urandom_range(31), $urandom_range(127));
  endfunction

  // Send one request; the tracker is updated at the accepting edge
  task automatic send_req(term_req_t r);
    term_req_t t;
    t = r;
    // Once the walk budget is spent, turn a walking request into a read
    if (sb.scrolls + sb.clears >= WALK_BUDGET) begin
      if (t.action == ACT_CLEAR ||
          (t.action == ACT_PUT && sb.crow == ROWS - 1 &&
           (t.ch == CH_NEWLINE || (t.ch != CH_BACKSPACE && sb.ccol == COLUMNS - 1))))
        t.action = ACT_READ;
    end
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, t.rcol, t.rrow, t.ch, t.action};
    do @(posedge clk); while (!in_tready);
    sb.note_request(t);
  endtask

  // Stop the stream and wait for every due result, plus a short settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_color(logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.color = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 8'($urandom_range(255));
  endtask

  task automatic run_directed();
    send_req(mk_req(ACT_READ, 8'h00, 0, 0));
    send_req(mk_req(ACT_READ, 8'hFF, ROWS - 1, COLUMNS - 1));
    // Reads off the screen
    send_req(mk_req(ACT_READ, 8'h00, ROWS, 0));
    send_req(mk_req(ACT_READ, 8'h00, 31, 127));
    send_req(mk_req(ACT_READ, 8'h00, 0, COLUMNS));
    send_req(mk_req(ACT_UNUSED, 8'hFF, 31, 127));
    // Backspace at column 0 blanks in place
    send_req(mk_cmd(ACT_PUT, CH_BACKSPACE));
    send_req(mk_cmd(ACT_PUT, 8'h00));
    send_req(mk_cmd(ACT_PUT, 8'hFF));
    send_req(mk_cmd(ACT_PUT, 8'h41));
    send_req(mk_req(ACT_READ, 8'h00, 0, 1));
    send_req(mk_cmd(ACT_PUT, CH_BACKSPACE));
    send_req(mk_req(ACT_READ, 8'h00, 0, 2));
    send_req(mk_cmd(ACT_PUT, CH_NEWLINE));
    send_req(mk_cmd(ACT_PUT, 8'h7F));
    send_req(mk_req(ACT_READ, 8'h00, 1, 0));
    send_req(mk_cmd(ACT_CLEAR, 8'h00));
    send_req(mk_req(ACT_READ, 8'h00, 0, 0));
    send_req(mk_req(ACT_READ, 8'h00, 14, 5));
    send_req(mk_req(ACT_READ, 8'h00, 15, COLUMNS - 1));
    send_req(mk_req(ACT_READ, 8'h00, ROWS - 1, 0));
    send_req(mk_cmd(ACT_PUT, CH_SPACE));
    send_req(mk_req(ACT_READ, 8'h00, 0, 0));
  endtask

  // Random bursts: mostly well-formed text, some walks, reads and noise
  task automatic run_segment(int n_items);
    int sent;
    int len;
    int pick;
    int k;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // Text with occasional newline, backspace and nearby reads
        len = $urandom_range(30, 5);
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(99);
          if (pick < 15)
            send_req(mk_req(ACT_READ, BYTE_W'($urandom_range(255)), sb.crow,
                            $urandom_range(79)));
          else if (pick < 22) send_req(mk_cmd(ACT_PUT, CH_NEWLINE));
          else if (pick < 29) send_req(mk_cmd(ACT_PUT, CH_BACKSPACE));
          else send_req(mk_cmd(ACT_PUT, BYTE_W'($urandom_range(255))));
        end
        sent += len;
      end else if (pick < 60) begin
        // Fill to the end of the line and wrap
        len = COLUMNS - sb.ccol + $urandom_range(2);
        for (k = 0; k < len; k++)
          send_req(mk_cmd(ACT_PUT, BYTE_W'($urandom_range(126, 32))));
        send_req(mk_req(ACT_READ, 8'h00, sb.crow, $urandom_range(79)));
        sent += len + 1;
      end else if (pick < 70) begin
        // Newlines down to the bottom and past it, then look at the screen
        len = ROWS - 1 - sb.crow + $urandom_range(2, 1);
        for (k = 0; k < len; k++) send_req(mk_cmd(ACT_PUT, CH_NEWLINE));
        for (k = 0; k < 3; k++)
          send_req(mk_req(ACT_READ, 8'h00, $urandom_range(24), $urandom_range(79)));
        sent += len + 3;
      end else if (pick < 80) begin
        // Read sweep, in and off the screen
        len = $urandom_range(8, 3);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(1))
            send_req(mk_req(ACT_READ, BYTE_W'($urandom_range(255)), $urandom_range(24),
                            $urandom_range(79)));
          else
            send_req(mk_req(ACT_READ, BYTE_W'($urandom_range(255)), $urandom_range(31),
                            $urandom_range(127)));
        end
        sent += len;
      end else if (pick < 90) begin
        // Noise: any action, any fields
        len = $urandom_range(5, 1);
        for (k = 0; k < len; k++)
          send_req(mk_req(ACT_W'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                          $urandom_range(31), $urandom_range(127)));
        sent += len;
      end else if (pick < 95) begin
        send_req(mk_cmd(ACT_CLEAR, BYTE_W'($urandom_range(255))));
        sent++;
      end else begin
        len = $urandom_range(6, 1);
        for (k = 0; k < len; k++) send_req(mk_cmd(ACT_PUT, CH_BACKSPACE));
        sent += len;
      end
    end
  endtask

  // Main sequence
  initial begin
    logic [7:0] seg_color [6];
    sb = new();
    seg_color[0] = 8'h00;
    seg_color[1] = 8'hFF;
    seg_color[2] = 8'($urandom_range(255));
    seg_color[3] = 8'h80;
    seg_color[4] = 8'($urandom_range(255));
    seg_color[5] = 8'h7F;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    for (int seg = 0; seg < 6; seg++) begin
      // Pacing: sender 15/receiver 48, then swapped, then none
      case (seg / 2)
        0: begin send_idle = 15; recv_idle = 48; end
        1: begin send_idle = 48; recv_idle = 15; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      drain();
      write_color(seg_color[seg]);
      run_segment(SEG_ITEMS);
    end
    drain();
    repeat (20) @(posedge clk);

    $display("summary: %0d requests, %0d results checked, %0d reads, %0d scrolls, %0d clears",
             sb.noted, sb.checked, sb.reads, sb.scrolls, sb.clears);
    $display("summary: six text colors incl. 0x00 and 0xFF over three pacing phases");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
